// ----- design/olir_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package olir_pkg;

	// Request codes carried on the input side band
	typedef enum logic [2:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_POP_BACK   = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_PUSH_FRONT = 3'd3,
		REQ_INSERT     = 3'd4,
		REQ_READ       = 3'd5
	} req_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_BADIX = 2'd3
	} status_t;

	// Field widths
	localparam int unsigned REQ_W    = 3;
	localparam int unsigned POS_W    = 5;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CNTO_W   = 5;
	localparam int unsigned DATA_W   = 40;

	// Control handed to the entry array for one executed request
	typedef struct packed {
		logic ins;   // open a gap at the index and place the word there
		logic rem;   // drop entry 0, move the rest down one place
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/olir_cells.sv -----
`timescale 1ns / 1ps
`default_nettype none

module olir_cells #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire                                  clk,
	input  olir_pkg::cell_ctl_t                  ctl,
	input  wire [$clog2(CAPACITY)-1:0]           at_idx,
	input  wire [olir_pkg::WORD_W-1:0]           word,
	input  wire [$clog2(CAPACITY)-1:0]           rd_idx,
	output logic [olir_pkg::WORD_W-1:0]          rd_word
);

	localparam int unsigned IDX_W = $clog2(CAPACITY);

	logic [olir_pkg::WORD_W-1:0] entries_q [CAPACITY];

	// Each cell picks hold, left neighbor, right neighbor or the new word
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [olir_pkg::WORD_W-1:0] lft;
		logic [olir_pkg::WORD_W-1:0] rgt;
		logic [IDX_W-1:0]            idx;

		assign idx = IDX_W'(g);

		if (g == 0) begin : g_first
			assign lft = word;
		end else begin : g_mid_l
			assign lft = entries_q[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign rgt = entries_q[g];
		end else begin : g_mid_r
			assign rgt = entries_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (ctl.ins) begin
				if (idx == at_idx) begin
					entries_q[g] <= word;
				end else if (idx > at_idx) begin
					entries_q[g] <= lft;
				end
			end else if (ctl.rem) begin
				entries_q[g] <= rgt;
			end
		end
	end

	// Read port
	assign rd_word = entries_q[rd_idx];

endmodule

`default_nettype wire

// ----- design/ordered_list_insert_remove.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit words.
// Input stream (s_*): one request per transfer. s_tuser holds the request
// kind (push back, pop back, remove front, push front, insert at index,
// read at index); s_tdata holds the index and the word to store.
// Output stream (m_*): exactly one result per request, in order. m_tuser
// holds the status (ok, full, empty, bad index); m_tdata holds the count
// after the request and the word read (zero unless a read succeeded).
// Timing: a request is registered in the request stage on acceptance and
// executed against the list from there; its result is registered in the
// result stage, which drives m_tvalid.
// Throughput: one request per cycle when not stalled; every entry register
// picks its next value from itself, a neighbor or the new word in parallel.
// Reset: arst_n empties the list and drops both pipeline stages; stored
// words are not cleared, since only entries below the count are visible.
// Stall: while m_tready is low the result holds, the request stage holds
// behind it and s_tready falls once both are occupied.
module ordered_list_insert_remove #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,   // [4:0] position, [36:5] word_in, [39:37] zero
	input  wire  [2:0]  s_tuser,   // [2:0] req_type
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // [4:0] count_after, [36:5] word_out, [39:37] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int unsigned IDX_W = $clog2(CAPACITY);
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned CMP_W = (CNT_W > olir_pkg::POS_W) ? CNT_W : olir_pkg::POS_W;

	// Request stage
	logic                               valid_s1;
	logic [olir_pkg::REQ_W-1:0]         req_s1;
	logic [olir_pkg::POS_W-1:0]         pos_s1;
	logic [olir_pkg::WORD_W-1:0]        word_s1;

	// Result stage
	logic                               valid_s2;
	olir_pkg::status_t                  status_s2;
	logic [olir_pkg::CNTO_W-1:0]        count_s2;
	logic [olir_pkg::WORD_W-1:0]        word_s2;

	logic [CNT_W-1:0]                   count_q;

	logic                               advance;
	logic                               exec;
	logic                               full;
	logic                               empty;
	logic [CMP_W-1:0]                   pos_cmp;
	logic [CMP_W-1:0]                   cnt_cmp;
	olir_pkg::status_t                  status_nx;
	logic [CNT_W-1:0]                   count_nx;
	logic                               rd_ok;
	olir_pkg::cell_ctl_t                ctl;
	logic [IDX_W-1:0]                   at_idx;
	logic [IDX_W-1:0]                   rd_idx;
	logic [olir_pkg::WORD_W-1:0]        rd_word;

	assign advance  = !valid_s2 || m_tready;
	assign exec     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1  <= s_tuser;
			pos_s1  <= s_tdata[4:0];
			word_s1 <= s_tdata[36:5];
		end
	end

	// Decide status, new count and entry-array control
	assign full    = (count_q == CNT_W'(CAPACITY));
	assign empty   = (count_q == '0);
	assign pos_cmp = CMP_W'(pos_s1);
	assign cnt_cmp = CMP_W'(count_q);
	assign rd_idx  = IDX_W'(pos_s1);

	always_comb begin
		status_nx = olir_pkg::ST_OK;
		count_nx  = count_q;
		rd_ok     = 1'b0;
		ctl       = '0;
		at_idx    = '0;
		case (olir_pkg::req_t'(req_s1))
			olir_pkg::REQ_PUSH_BACK: begin
				if (full) begin
					status_nx = olir_pkg::ST_FULL;
				end else begin
					ctl.ins  = 1'b1;
					at_idx   = IDX_W'(count_q);
					count_nx = count_q + 1'b1;
				end
			end
			olir_pkg::REQ_POP_BACK: begin
				if (empty) begin
					status_nx = olir_pkg::ST_EMPTY;
				end else begin
					count_nx = count_q - 1'b1;
				end
			end
			olir_pkg::REQ_POP_FRONT: begin
				if (empty) begin
					status_nx = olir_pkg::ST_EMPTY;
				end else begin
					ctl.rem  = 1'b1;
					count_nx = count_q - 1'b1;
				end
			end
			olir_pkg::REQ_PUSH_FRONT: begin
				if (full) begin
					status_nx = olir_pkg::ST_FULL;
				end else begin
					ctl.ins  = 1'b1;
					count_nx = count_q + 1'b1;
				end
			end
			olir_pkg::REQ_INSERT: begin
				if (full) begin
					status_nx = olir_pkg::ST_FULL;
				end else if (pos_cmp > cnt_cmp) begin
					status_nx = olir_pkg::ST_BADIX;
				end else begin
					ctl.ins  = 1'b1;
					at_idx   = IDX_W'(pos_s1);
					count_nx = count_q + 1'b1;
				end
			end
			olir_pkg::REQ_READ: begin
				if (pos_cmp >= cnt_cmp) begin
					status_nx = olir_pkg::ST_BADIX;
				end else begin
					rd_ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (!exec) begin
			ctl = '0;
		end
	end

	olir_cells #(
		.CAPACITY (CAPACITY)
	) u_cells (
		.clk     (clk),
		.ctl     (ctl),
		.at_idx  (at_idx),
		.word    (word_s1),
		.rd_idx  (rd_idx),
		.rd_word (rd_word)
	);

	// Advance the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (exec) begin
			count_q <= count_nx;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			status_s2 <= status_nx;
			count_s2  <= olir_pkg::CNTO_W'(count_nx);
			word_s2   <= rd_ok ? rd_word : '0;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = status_s2;
	assign m_tdata  = {3'b000, word_s2, count_s2};

	// Count never exceeds the capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("list count above capacity");

	// A full status is only given when the list is at capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		exec && status_nx == olir_pkg::ST_FULL |-> full)
		else $error("full status on a list with room");

	// A successful pop from the back takes exactly one entry
	assert property (@(posedge clk) disable iff (!arst_n)
		exec && !empty && olir_pkg::req_t'(req_s1) == olir_pkg::REQ_POP_BACK
		|=> count_q == $past(count_q) - 1'b1)
		else $error("pop did not shrink the list by one");

	// A request held behind a stalled result stays in place
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(req_s1) && $stable(pos_s1))
		else $error("request stage lost a pending request");

	// Entry array is touched only when a request executes
	assert property (@(posedge clk) disable iff (!arst_n)
		!exec |-> !ctl.ins && !ctl.rem)
		else $error("entry array changed without a request");

endmodule

`default_nettype wire
